@@ sv/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg: shared types and codes for the sorted array table
// Word layouts, action and status codes, and controller/datapath handshake.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_FIND   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
        logic [3:0]  index;
    } t_in;

    typedef struct packed {
        logic [31:0] read_value;
        logic [3:0]  position;
        logic        found;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;

endpackage

@@ sv/sorted_array_table_unit.sv @@
// Lookup and find take one memory read per visited entry; insert and remove take
// one read and one write per moved entry on the entry memory, which has separate
// read and write ports, plus a start step. A new word is accepted only after the
// previous result has been handed to the output register.
// Reset: synchronous active low; clears count, capacity to 16 and handshakes.
// Entry memory is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_array_table_unit: sorted array table top level
// Ascending table with insert, lookup, remove and find on valid/ready words.
// ----------------------------------------------------------------------------
module sorted_array_table_unit #(
    parameter int DEPTH = sat_pkg::DEPTH_DEF,
    parameter int WIDTH = sat_pkg::WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  sat_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sat_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  logic [sat_pkg::CAP_W-1:0] i_cfg_data
);

    sat_pkg::t_cmd w_cmd;
    sat_pkg::t_sts w_sts;

    sat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sat_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in       (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a word but stayed ready");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == sat_pkg::ST_FULL) |->
        (o_out_data.read_value == '0 && o_out_data.position == '0 && !o_out_data.found))
        else $error("table full result carries data");

    a_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == sat_pkg::ST_RANGE) |->
        (o_out_data.read_value == '0 && o_out_data.position == '0 && !o_out_data.found))
        else $error("out of range result carries data");

    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a word in progress");

endmodule

@@ sv/sat_ctrl.sv @@
// ----------------------------------------------------------------------------
// sat_ctrl: sequencer for the sorted array table
// Accepts a word, starts the datapath, steps it until done, hands off result.
// ----------------------------------------------------------------------------
module sat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sat_pkg::t_sts i_sts,
    output sat_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld;
        o_cmd     = '0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.done ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

@@ sv/sat_dp.sv @@
// ----------------------------------------------------------------------------
// sat_dp: datapath for the sorted array table
// Entry memory, count, scan pointer, capacity register and result registers.
// ----------------------------------------------------------------------------
module sat_dp #(
    parameter int DEPTH = sat_pkg::DEPTH_DEF,
    parameter int WIDTH = sat_pkg::WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sat_pkg::t_cmd               i_cmd,
    output sat_pkg::t_sts               o_sts,
    input  sat_pkg::t_in                i_in,
    input  logic                        i_cfg_we,
    input  logic [sat_pkg::CAP_W-1:0]   i_cfg_data,
    output sat_pkg::t_out               o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > sat_pkg::CAP_W) ? CW : sat_pkg::CAP_W;

    logic [WIDTH-1:0]          r_mem [DEPTH];
    logic [WIDTH-1:0]          r_rdata;

    logic [sat_pkg::CAP_W-1:0] r_cap;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [1:0]                r_act;
    logic [WIDTH-1:0]          r_val;
    logic [3:0]                r_idx;
    logic [CW-1:0]             r_ptr;
    logic [CW-1:0]             n_ptr;
    logic                      r_fill;
    logic                      n_fill;
    sat_pkg::t_out             r_res;
    sat_pkg::t_out             r_out;

    logic [LW-1:0]             w_count_l;
    logic [LW-1:0]             w_lim;
    logic                      w_full;
    logic                      w_idx_bad;
    logic [CW-1:0]             w_last;
    logic [CW-1:0]             w_idx_c;
    logic [63:0]               w_rd64;

    logic                      w_done;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [WIDTH-1:0]          w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [31:0]               w_rv;
    logic [3:0]                w_pos;
    logic                      w_fnd;
    logic [1:0]                w_st;

    assign w_count_l = LW'(r_count);
    assign w_lim     = (LW'(r_cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_cap);
    assign w_full    = (w_count_l >= w_lim);
    assign w_idx_bad = (LW'(r_idx) >= w_count_l);
    assign w_last    = r_count - CW'(1);
    assign w_idx_c   = CW'(r_idx);
    assign w_rd64    = 64'(r_rdata);

    always_comb begin
        w_done  = 1'b0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_val;
        w_raddr = '0;
        n_ptr   = r_ptr;
        n_fill  = r_fill;
        n_count = r_count;
        w_rv    = '0;
        w_pos   = '0;
        w_fnd   = 1'b0;
        w_st    = sat_pkg::ST_OK;

        if (i_cmd.start) begin
            unique case (r_act)
                sat_pkg::ACT_INSERT: begin
                    if (w_full) begin
                        w_done = 1'b1;
                        w_st   = sat_pkg::ST_FULL;
                    end else if (r_count == '0) begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        w_done  = 1'b1;
                    end else begin
                        // walk down from the top entry
                        w_raddr = AW'(w_last);
                        n_ptr   = w_last;
                    end
                end
                sat_pkg::ACT_LOOKUP: begin
                    if (w_idx_bad) begin
                        w_done = 1'b1;
                        w_st   = sat_pkg::ST_RANGE;
                    end else begin
                        w_raddr = AW'(w_idx_c);
                        n_ptr   = w_idx_c;
                    end
                end
                sat_pkg::ACT_REMOVE: begin
                    if (w_idx_bad) begin
                        w_done = 1'b1;
                        w_st   = sat_pkg::ST_RANGE;
                    end else if (w_idx_c == w_last) begin
                        n_count = w_last;
                        w_done  = 1'b1;
                    end else begin
                        w_raddr = AW'(w_idx_c + CW'(1));
                        n_ptr   = w_idx_c + CW'(1);
                    end
                end
                sat_pkg::ACT_FIND: begin
                    if (r_count == '0) begin
                        w_done = 1'b1;
                    end else begin
                        w_raddr = '0;
                        n_ptr   = '0;
                    end
                end
            endcase
        end else if (i_cmd.step) begin
            unique case (r_act)
                sat_pkg::ACT_INSERT: begin
                    if (r_fill) begin
                        // every entry moved up: new word lands in slot zero
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        w_done  = 1'b1;
                    end else if (r_rdata >= r_val) begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_ptr + CW'(1));
                        w_wdata = r_rdata;
                        if (r_ptr == '0) begin
                            n_fill = 1'b1;
                        end else begin
                            n_ptr   = r_ptr - CW'(1);
                            w_raddr = AW'(r_ptr - CW'(1));
                        end
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_ptr + CW'(1));
                        n_count = r_count + CW'(1);
                        w_pos   = 4'(r_ptr + CW'(1));
                        w_done  = 1'b1;
                    end
                end
                sat_pkg::ACT_LOOKUP: begin
                    w_rv   = w_rd64[31:0];
                    w_done = 1'b1;
                end
                sat_pkg::ACT_REMOVE: begin
                    // move each later entry down one slot
                    w_we    = 1'b1;
                    w_waddr = AW'(r_ptr - CW'(1));
                    w_wdata = r_rdata;
                    if (r_ptr == w_last) begin
                        n_count = w_last;
                        w_done  = 1'b1;
                    end else begin
                        n_ptr   = r_ptr + CW'(1);
                        w_raddr = AW'(r_ptr + CW'(1));
                    end
                end
                sat_pkg::ACT_FIND: begin
                    if (r_rdata == r_val) begin
                        w_fnd  = 1'b1;
                        w_pos  = 4'(r_ptr);
                        w_done = 1'b1;
                    end else if (r_ptr == w_last) begin
                        w_done = 1'b1;
                    end else begin
                        n_ptr   = r_ptr + CW'(1);
                        w_raddr = AW'(r_ptr + CW'(1));
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= sat_pkg::CAP_RESET;
            r_count <= '0;
            r_fill  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_count <= n_count;
            r_fill  <= i_cmd.load ? 1'b0 : n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_act <= i_in.action;
            r_val <= WIDTH'(i_in.value);
            r_idx <= i_in.index;
        end
        if (w_done) begin
            r_res.read_value  <= w_rv;
            r_res.position    <= w_pos;
            r_res.found       <= w_fnd;
            r_res.status      <= w_st;
            r_res.entry_count <= 5'(n_count);
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_sts.done = w_done;
    assign o_out      = r_out;

endmodule
